// ===== sv/pfsa_pkg.sv =====
// Package for the page free-stack allocator.
// Holds field widths, operation codes, register indexes and reset values.
// No dependencies.
package pfsa_pkg;

    localparam int OP_W       = 2;
    localparam int IDX_W      = 8;
    localparam int COUNT_W    = 9;
    localparam int BYTES_W    = 17;
    localparam int OFFSET_W   = 24;
    localparam int PROD_W     = IDX_W + BYTES_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BYTES_W;

    localparam int MAX_PAGES_DEFAULT = 256;
    localparam int POOL_LIMIT        = 511;
    localparam int PAGES_RESET       = 256;
    localparam int PAGE_BYTES_RESET  = 4096;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_ACQUIRE = 2'd0;
    localparam op_t OP_RELEASE = 2'd1;
    localparam op_t OP_LOOKUP  = 2'd2;
    localparam op_t OP_REINIT  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES   = 1'd1;

endpackage

// ===== sv/pfsa_cfg_if.sv =====
// Configuration write channel of the page free-stack allocator.
// Depends on pfsa_pkg.
interface pfsa_cfg_if;
    import pfsa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/pfsa_req_if.sv =====
// Request channel of the page free-stack allocator.
// Depends on pfsa_pkg.
interface pfsa_req_if;
    import pfsa_pkg::*;

    logic             valid;
    logic             ready;
    op_t              operation;
    logic [IDX_W-1:0] page_index;

    modport source (output valid, output operation, output page_index, input ready);
    modport sink   (input valid, input operation, input page_index, output ready);
endinterface

// ===== sv/pfsa_rsp_if.sv =====
// Result channel of the page free-stack allocator.
// Depends on pfsa_pkg.
interface pfsa_rsp_if;
    import pfsa_pkg::*;

    logic                valid;
    logic                ready;
    logic                ok;
    logic [IDX_W-1:0]    granted_index;
    logic [OFFSET_W-1:0] page_offset;
    logic [COUNT_W-1:0]  free_count;

    modport source (output valid, output ok, output granted_index, output page_offset,
                    output free_count, input ready);
    modport sink   (input valid, input ok, input granted_index, input page_offset,
                    input free_count, output ready);
endinterface

// ===== sv/page_free_stack_allocator.sv =====
// Page allocator over a LIFO stack of free page indices.
// Depends on pfsa_pkg, pfsa_cfg_if, pfsa_req_if and pfsa_rsp_if.
//
// Usage:
//   req carries one operation per transfer: acquire, release, lookup or
//   reinitialise, with a page index for release and lookup. rsp returns one
//   result per request: ok, the granted page, its byte offset and the free
//   page count after the operation. cfg writes pages_in_use (index 0, which
//   also refills the stack) and page_bytes (index 1); write it only while
//   no request is outstanding. cfg is always ready.
//   A request passes the stage-one register, then the result register
//   that drives rsp.valid. The stack and its top pointer update at the
//   request transfer, the stack read is registered, and the offset
//   multiply (8 x 17 bits) feeds the result register.
//   One request is taken per cycle while rsp is taken.
//   When rsp stalls, the result register and one request in flight hold;
//   req.ready drops when stage one is full, until the result is taken.
//   Reset needs no clearing pass: per-entry valid bits are cleared, and an
//   entry that is not valid reads as its own index, so after reset the stack
//   holds 0..N-1 with N = min(256, MAX_PAGES) free pages, page_bytes 4096.
//   A reinitialise request or a pages_in_use write refills it the same way.
module page_free_stack_allocator #(
    parameter int MAX_PAGES = pfsa_pkg::MAX_PAGES_DEFAULT
) (
    input logic         clk,
    input logic         rst_n,
    pfsa_cfg_if.sink    cfg,
    pfsa_req_if.sink    req,
    pfsa_rsp_if.source  rsp
);
    import pfsa_pkg::*;

    localparam int DEPTH = (MAX_PAGES > POOL_LIMIT) ? POOL_LIMIT : MAX_PAGES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [COUNT_W-1:0] CAP       = COUNT_W'(DEPTH);
    localparam logic [COUNT_W-1:0] RESET_TOP =
        (PAGES_RESET > DEPTH) ? CAP : COUNT_W'(PAGES_RESET);

    logic [COUNT_W-1:0] pages_reg;
    logic [BYTES_W-1:0] page_bytes_reg;
    logic [COUNT_W-1:0] top_reg;
    logic [COUNT_W-1:0] top_next;
    logic [DEPTH-1:0]   valid_reg;
    logic [IDX_W-1:0]   stack_mem [DEPTH];
    logic [IDX_W-1:0]   rd_data_reg;

    logic               s1_valid_reg;
    logic               s1_ok_reg;
    logic               s1_grant_reg;
    logic               s1_from_stack_reg;
    logic               s1_hit_reg;
    logic [IDX_W-1:0]   s1_addr_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic [COUNT_W-1:0] s1_count_reg;

    logic                rsp_valid_reg;
    logic                rsp_ok_reg;
    logic [IDX_W-1:0]    rsp_index_reg;
    logic [OFFSET_W-1:0] rsp_offset_reg;
    logic [COUNT_W-1:0]  rsp_count_reg;

    logic               accept;
    logic               advance;
    logic               cfg_wr;
    logic               cfg_pages_wr;
    logic [COUNT_W-1:0] pool;
    logic [COUNT_W-1:0] cfg_pool;
    logic [COUNT_W-1:0] top_dec;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               live;
    logic               idx_ok;
    logic               ok_now;
    logic               grant_now;
    logic               from_stack;
    logic               push;
    logic               refill;

    logic [IDX_W-1:0]    granted;
    logic [PROD_W-1:0]   product;
    logic [OFFSET_W-1:0] offset;

    assign cfg.ready    = 1'b1;
    assign cfg_wr       = cfg.valid && cfg.ready;
    assign cfg_pages_wr = cfg_wr && (cfg.index == CFG_PAGES_IN_USE);
    assign cfg_pool     = (cfg.data[COUNT_W-1:0] > CAP) ? CAP : cfg.data[COUNT_W-1:0];

    assign advance   = !rsp_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || advance;
    assign accept    = req.valid && req.ready;

    assign pool    = (pages_reg > CAP) ? CAP : pages_reg;
    assign live    = (pool != '0);
    assign idx_ok  = ({1'b0, req.page_index} < pool);
    assign top_dec = top_reg - COUNT_W'(1);
    assign rd_addr = top_dec[AW-1:0];
    assign wr_addr = top_reg[AW-1:0];

    always_comb
    begin
        top_next   = top_reg;
        ok_now     = 1'b0;
        grant_now  = 1'b0;
        from_stack = 1'b0;
        push       = 1'b0;
        refill     = 1'b0;
        case (req.operation)
            OP_ACQUIRE:
            begin
                if (live && (top_reg != '0))
                begin
                    top_next   = top_dec;
                    ok_now     = 1'b1;
                    grant_now  = 1'b1;
                    from_stack = 1'b1;
                end
            end
            OP_RELEASE:
            begin
                if (live && idx_ok && (top_reg < pool))
                begin
                    top_next = top_reg + COUNT_W'(1);
                    ok_now   = 1'b1;
                    push     = 1'b1;
                end
            end
            OP_LOOKUP:
            begin
                if (live && idx_ok)
                begin
                    ok_now    = 1'b1;
                    grant_now = 1'b1;
                end
            end
            default:
            begin
                top_next = pool;
                ok_now   = live;
                refill   = 1'b1;
            end
        endcase
    end

    // Configuration and stack pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_reg      <= COUNT_W'(PAGES_RESET);
            page_bytes_reg <= BYTES_W'(PAGE_BYTES_RESET);
            top_reg        <= RESET_TOP;
            valid_reg      <= '0;
        end
        else
        begin
            if (cfg_pages_wr)
            begin
                pages_reg <= cfg.data[COUNT_W-1:0];
                top_reg   <= cfg_pool;
                valid_reg <= '0;
            end
            else if (accept)
            begin
                top_reg <= top_next;
                if (refill)
                begin
                    valid_reg <= '0;
                end
                else if (push)
                begin
                    valid_reg[wr_addr] <= 1'b1;
                end
            end
            if (cfg_wr && (cfg.index == CFG_PAGE_BYTES))
            begin
                page_bytes_reg <= cfg.data[BYTES_W-1:0];
            end
        end
    end

    // Stack memory: write on release, registered read on transfer
    always_ff @(posedge clk)
    begin
        if (accept && push)
        begin
            stack_mem[wr_addr] <= req.page_index;
        end
        if (accept)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    // Stage one: operation outcome
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ok_reg         <= ok_now;
            s1_grant_reg      <= grant_now;
            s1_from_stack_reg <= from_stack;
            s1_hit_reg        <= valid_reg[rd_addr];
            s1_addr_reg       <= top_dec[IDX_W-1:0];
            s1_idx_reg        <= req.page_index;
            s1_count_reg      <= top_next;
        end
    end

    assign granted = !s1_grant_reg ? '0
                   : !s1_from_stack_reg ? s1_idx_reg
                   : s1_hit_reg ? rd_data_reg
                   : s1_addr_reg;

    assign product = PROD_W'(granted) * PROD_W'(page_bytes_reg);
    assign offset  = (product[PROD_W-1:OFFSET_W] != '0) ? '1 : product[OFFSET_W-1:0];

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            rsp_ok_reg     <= s1_ok_reg;
            rsp_index_reg  <= granted;
            rsp_offset_reg <= offset;
            rsp_count_reg  <= s1_count_reg;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.ok            = rsp_ok_reg;
    assign rsp.granted_index = rsp_index_reg;
    assign rsp.page_offset   = rsp_offset_reg;
    assign rsp.free_count    = rsp_count_reg;

endmodule
